### rtl/core/wear_levelled_log_kv_store_defines.svh
// Assertion macros shared by the key/value store modules.
`ifndef WEAR_LEVELLED_LOG_KV_STORE_DEFINES_SVH
`define WEAR_LEVELLED_LOG_KV_STORE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define WLKV_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("wlkv: invariant violated");

// A condition that forces another one at the following clock edge.
`define WLKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wlkv: sequence violated");

`endif

### rtl/core/wlkv_pkg.sv
// Types, codes and CRC tables shared by the key/value store modules.
`default_nettype none

package wlkv_pkg;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_RECOVER = 2'd0,
    OP_PUT     = 2'd1,
    OP_DELETE  = 2'd2,
    OP_GET     = 2'd3
  } opcode_e;

  // Record tags and row header mark.
  localparam logic [7:0] TAG_PUT  = 8'h01;
  localparam logic [7:0] TAG_DEL  = 8'h02;
  localparam logic [7:0] ROW_MARK = 8'h7F;
  localparam logic [3:0] LAST_SLOT = 4'd14;
  localparam logic [3:0] HDR_SLOT  = 4'd15;
  localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

  // Input and result words.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] key;
    logic [4:0]  value;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] found_value;
  } out_t;

  // Micro-operations issued by the controller to the datapath.
  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_CLEAR,
    UOP_LOAD,
    UOP_APPEND,
    UOP_ROLL_RD,
    UOP_ROLL_SEQ,
    UOP_ERASE,
    UOP_GET_STEP,
    UOP_GET_CHK,
    UOP_HDR_RD,
    UOP_HDR_CHK,
    UOP_SLOT_RD,
    UOP_SLOT_CHK,
    UOP_OUT
  } uop_e;

  typedef struct packed {
    uop_e uop;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic slot_full;
    logic hdr_last;
    logic slot_last;
    logic erase_last;
    logic rec_good;
    logic key_hit;
    logic walk_end;
  } sts_t;

  // CRC-8, polynomial 0x31, MSB first, evaluated at elaboration only.
  typedef logic [7:0] crc_tab_t [256];

  function automatic logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ 8'h31) : (r << 1);
    end
    return r;
  endfunction

  // Table of the CRC of one byte followed by a number of zero bytes.
  function automatic crc_tab_t crc_tab_gen(int unsigned zeros);
    crc_tab_t   t;
    logic [7:0] c;
    for (int i = 0; i < 256; i++) begin
      c = crc_byte(8'h00, 8'(i));
      for (int unsigned z = 0; z < zeros; z++) begin
        c = crc_byte(c, 8'h00);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TAB0 = crc_tab_gen(0);
  localparam crc_tab_t CRC_TAB1 = crc_tab_gen(1);
  localparam crc_tab_t CRC_TAB2 = crc_tab_gen(2);

  // The CRC is linear, so the three bytes combine by XOR of table reads.
  function automatic logic [7:0] crc_rec(logic [23:0] d);
    return CRC_TAB2[d[7:0]] ^ CRC_TAB1[d[15:8]] ^ CRC_TAB0[d[23:16]];
  endfunction

endpackage

`default_nettype wire

### rtl/core/wlkv_ctrl.sv
// Controller state machine that sequences every operation of the store.
`default_nettype none
`include "wear_levelled_log_kv_store_defines.svh"

module wlkv_ctrl import wlkv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] opcode_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output cmd_t            cmd_o,
  input  wire sts_t       sts_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_APPEND,
    S_ROLL_RD,
    S_ROLL_SEQ,
    S_ERASE,
    S_GET_STEP,
    S_GET_CHK,
    S_HDR_RD,
    S_HDR_CHK,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Next state, command and output valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.uop   = UOP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.uop = UOP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.uop = UOP_LOAD;
          unique case (opcode_e'(opcode_i))
            OP_RECOVER:       state_d = S_HDR_RD;
            OP_PUT, OP_DELETE: state_d = S_APPEND;
            OP_GET:           state_d = S_GET_STEP;
            default:          state_d = S_DONE;
          endcase
        end
      end
      S_APPEND: begin
        cmd_o.uop = UOP_APPEND;
        state_d   = sts_i.slot_full ? S_ROLL_RD : S_DONE;
      end
      S_ROLL_RD: begin
        cmd_o.uop = UOP_ROLL_RD;
        state_d   = S_ROLL_SEQ;
      end
      S_ROLL_SEQ: begin
        cmd_o.uop = UOP_ROLL_SEQ;
        state_d   = S_ERASE;
      end
      S_ERASE: begin
        cmd_o.uop = UOP_ERASE;
        if (sts_i.erase_last) state_d = S_DONE;
      end
      S_GET_STEP: begin
        cmd_o.uop = UOP_GET_STEP;
        state_d   = S_GET_CHK;
      end
      S_GET_CHK: begin
        cmd_o.uop = UOP_GET_CHK;
        priority if (!sts_i.rec_good || sts_i.key_hit || sts_i.walk_end) begin
          state_d = S_DONE;
        end else begin
          state_d = S_GET_STEP;
        end
      end
      S_HDR_RD: begin
        cmd_o.uop = UOP_HDR_RD;
        state_d   = S_HDR_CHK;
      end
      S_HDR_CHK: begin
        cmd_o.uop = UOP_HDR_CHK;
        state_d   = sts_i.hdr_last ? S_SLOT_RD : S_HDR_RD;
      end
      S_SLOT_RD: begin
        cmd_o.uop = UOP_SLOT_RD;
        state_d   = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        cmd_o.uop = UOP_SLOT_CHK;
        priority if (!sts_i.rec_good) begin
          state_d = S_DONE;
        end else if (sts_i.slot_last) begin
          state_d = S_ROLL_RD;
        end else begin
          state_d = S_SLOT_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.uop   = UOP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `WLKV_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE)
  `WLKV_ASSERT_NEXT(a_result_shown, cmd_o.uop == UOP_OUT, out_valid_q)

endmodule

`default_nettype wire

### rtl/core/wlkv_dp.sv
// Datapath: log memory, cursors, scan counter, CRC check and result register.
`default_nettype none
`include "wear_levelled_log_kv_store_defines.svh"

module wlkv_dp import wlkv_pkg::*; #(
  parameter int unsigned NUM_ROWS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output out_t      out_o
);

  localparam int unsigned RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned AW    = RW + 4;
  localparam int unsigned DEPTH = NUM_ROWS * 16;
  localparam logic [RW-1:0] LAST_ROW = RW'(NUM_ROWS - 1);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [31:0]   mem_wdata;

  logic [RW-1:0] wr_row_q, wr_row_d;
  logic [3:0]    wr_slot_q, wr_slot_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [3:0]    cur_slot_q, cur_slot_d;
  logic [7:0]    best_seq_q, best_seq_d;
  logic [RW-1:0] best_row_q, best_row_d;
  logic [7:0]    seq_q, seq_d;
  logic [1:0]    op_q, op_d;
  logic [10:0]   key_q, key_d;
  logic [4:0]    val_q, val_d;
  logic          res_ok_q, res_ok_d;
  logic [4:0]    res_val_q, res_val_d;
  out_t          out_q, out_d;

  logic [RW-1:0] next_row, prev_row;
  logic [3:0]    prev_slot;
  logic [7:0]    rec_tag;
  logic [31:0]   rec_word;
  logic [7:0]    seq_gap;
  logic          hdr_upd;
  logic [RW-1:0] hdr_row;

  // Circular neighbors of the cursors.
  assign next_row  = (wr_row_q == LAST_ROW) ? '0 : wr_row_q + 1'b1;
  assign prev_row  = (cur_slot_q == 4'd0) ?
                     ((cur_row_q == '0) ? LAST_ROW : cur_row_q - 1'b1) : cur_row_q;
  assign prev_slot = (cur_slot_q == 4'd0) ? LAST_SLOT : cur_slot_q - 4'd1;

  // Record word to append, with its CRC in the top byte.
  assign rec_tag  = (opcode_e'(op_q) == OP_DELETE) ? TAG_DEL : TAG_PUT;
  assign rec_word = {crc_rec({key_q[2:0],
                              (opcode_e'(op_q) == OP_DELETE) ? 5'd0 : val_q,
                              key_q[10:3], rec_tag}),
                     key_q[2:0], (opcode_e'(op_q) == OP_DELETE) ? 5'd0 : val_q,
                     key_q[10:3], rec_tag};

  // Header scan: is this row ahead of the best by 1..127.
  assign hdr_row = cnt_q[RW-1:0];
  assign seq_gap = rdata_q[23:16] - best_seq_q;
  assign hdr_upd = (rdata_q[31:24] == ROW_MARK) && (seq_gap != 8'd0) && !seq_gap[7];

  // Status back to the controller.
  assign sts_o.clr_last   = (cnt_q == AW'(DEPTH - 1));
  assign sts_o.slot_full  = (wr_slot_q == LAST_SLOT);
  assign sts_o.hdr_last   = (hdr_row == LAST_ROW);
  assign sts_o.slot_last  = (cnt_q[3:0] == LAST_SLOT);
  assign sts_o.erase_last = (cnt_q[3:0] == HDR_SLOT);
  assign sts_o.rec_good   = (rdata_q[31:24] == crc_rec(rdata_q[23:0]));
  assign sts_o.key_hit    = ({rdata_q[15:8], rdata_q[23:21]} == key_q);
  assign sts_o.walk_end   = (cur_row_q == wr_row_q) && (cur_slot_q == 4'd0);

  assign out_o = out_q;

  // Memory port address and write data.
  always_comb begin
    mem_addr  = {wr_row_q, wr_slot_q};
    mem_we    = 1'b0;
    mem_wdata = ERASED_WORD;
    unique case (cmd_i.uop)
      UOP_CLEAR: begin
        mem_addr = cnt_q;
        mem_we   = 1'b1;
      end
      UOP_APPEND: begin
        mem_we    = 1'b1;
        mem_wdata = rec_word;
      end
      UOP_ROLL_RD:  mem_addr = {wr_row_q, HDR_SLOT};
      UOP_ERASE: begin
        mem_addr = {next_row, cnt_q[3:0]};
        mem_we   = 1'b1;
        if (cnt_q[3:0] == HDR_SLOT) mem_wdata = {ROW_MARK, seq_q, 16'hFFFF};
      end
      UOP_GET_STEP: mem_addr = {prev_row, prev_slot};
      UOP_HDR_RD:   mem_addr = {hdr_row, HDR_SLOT};
      UOP_SLOT_RD:  mem_addr = {wr_row_q, cnt_q[3:0]};
      default: ;
    endcase
  end

  // Register updates per micro-operation.
  always_comb begin
    wr_row_d   = wr_row_q;
    wr_slot_d  = wr_slot_q;
    cnt_d      = cnt_q;
    cur_row_d  = cur_row_q;
    cur_slot_d = cur_slot_q;
    best_seq_d = best_seq_q;
    best_row_d = best_row_q;
    seq_d      = seq_q;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    res_ok_d   = res_ok_q;
    res_val_d  = res_val_q;
    out_d      = out_q;
    unique case (cmd_i.uop)
      UOP_CLEAR: cnt_d = cnt_q + 1'b1;
      UOP_LOAD: begin
        op_d       = in_i.opcode;
        key_d      = in_i.key;
        val_d      = in_i.value;
        res_ok_d   = (opcode_e'(in_i.opcode) != OP_GET);
        res_val_d  = 5'd0;
        cur_row_d  = wr_row_q;
        cur_slot_d = wr_slot_q;
        cnt_d      = '0;
        best_seq_d = 8'd0;
        best_row_d = '0;
      end
      UOP_APPEND: begin
        if (wr_slot_q != LAST_SLOT) wr_slot_d = wr_slot_q + 4'd1;
      end
      UOP_ROLL_SEQ: begin
        seq_d = rdata_q[23:16] + 8'd1;
        cnt_d = '0;
      end
      UOP_ERASE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[3:0] == HDR_SLOT) begin
          wr_row_d  = next_row;
          wr_slot_d = 4'd0;
        end
      end
      UOP_GET_STEP: begin
        cur_row_d  = prev_row;
        cur_slot_d = prev_slot;
      end
      UOP_GET_CHK: begin
        if (sts_o.rec_good && sts_o.key_hit && (rdata_q[7:0] != TAG_DEL)) begin
          res_ok_d  = 1'b1;
          res_val_d = rdata_q[20:16];
        end
      end
      UOP_HDR_CHK: begin
        if (hdr_upd) begin
          best_seq_d = rdata_q[23:16];
          best_row_d = hdr_row;
        end
        if (sts_o.hdr_last) begin
          wr_row_d = hdr_upd ? hdr_row : best_row_q;
          cnt_d    = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      UOP_SLOT_CHK: begin
        if (!sts_o.rec_good) wr_slot_d = cnt_q[3:0];
        else                 cnt_d     = cnt_q + 1'b1;
      end
      UOP_OUT: begin
        out_d.ok          = res_ok_q;
        out_d.found_value = res_val_q;
      end
      default: ;
    endcase
  end

  // Single-port log memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  // Cursor and scan counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_row_q  <= '0;
      wr_slot_q <= 4'd0;
      cnt_q     <= '0;
    end else begin
      wr_row_q  <= wr_row_d;
      wr_slot_q <= wr_slot_d;
      cnt_q     <= cnt_d;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    cur_row_q  <= cur_row_d;
    cur_slot_q <= cur_slot_d;
    best_seq_q <= best_seq_d;
    best_row_q <= best_row_d;
    seq_q      <= seq_d;
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    res_ok_q   <= res_ok_d;
    res_val_q  <= res_val_d;
    out_q      <= out_d;
  end

  `WLKV_ASSERT_ALWAYS(a_slot_in_range, wr_slot_q <= LAST_SLOT)
  `WLKV_ASSERT_ALWAYS(a_row_in_range, wr_row_q <= LAST_ROW)

endmodule

`default_nettype wire

### rtl/core/wear_levelled_log_kv_store.sv
// Put/delete appends one record, and when the row fills it also erases the next row and writes its header.
// Get walks the log backward one record slot at a time, a read then a check, on the single memory port.
// Recover reads all NUM_ROWS row headers, then checks slots of the newest row, plus a roll when the row is full.
// One word is in flight at a time; the next word is taken while a result waits for ready.
// After reset the log is erased one word per cycle, all 16*NUM_ROWS words, with in_ready_o low.
`default_nettype none

module wear_levelled_log_kv_store import wlkv_pkg::*; #(
  parameter int unsigned NUM_ROWS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  cmd_t cmd;
  sts_t sts;

  wlkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (in_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  wlkv_dp #(
    .NUM_ROWS (NUM_ROWS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

### bench/wear_levelled_log_kv_store_tb.sv
// Testbench for the log-structured key/value store: random handshakes checked against a predictor.
`timescale 1ns / 1ps

module wear_levelled_log_kv_store_tb;
  import wlkv_pkg::*;

  localparam int unsigned ROWS = 16;
  localparam int unsigned WORDS = ROWS * 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  // Predictor state: a shadow copy of the log and its write cursor.
  logic [31:0] shadow_log [WORDS];
  int unsigned cur_row;
  int unsigned cur_slot;

  in_t  pending_words [$];
  out_t expected_results [$];
  int   fail_count = 0;
  bit   stim_done = 1'b0;
  bit   quiet_sender = 1'b0;
  bit   quiet_receiver = 1'b0;
  int   hold_cycles = 0;
  bit   hold_armed = 1'b0;

  wear_levelled_log_kv_store #(.NUM_ROWS(ROWS)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_i(in_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  always #2 clk_i = ~clk_i;

  // CRC-8 over the low three bytes of a record word, bit by bit.
  function automatic logic [7:0] record_crc(logic [31:0] w);
    logic [7:0] c;
    c = 8'h00;
    for (int b = 0; b < 3; b++) begin
      c = c ^ w[8*b +: 8];
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
      end
    end
    return c;
  endfunction

  function automatic bit record_good(logic [31:0] w);
    return w[31:24] == record_crc(w);
  endfunction

  // Erase the next row and give it a header one sequence ahead.
  task automatic advance_row();
    int unsigned nxt;
    logic [7:0] seq;
    nxt = (cur_row + 1) % ROWS;
    seq = shadow_log[cur_row*16 + HDR_SLOT][23:16] + 8'd1;
    for (int s = 0; s < 16; s++) shadow_log[nxt*16 + s] = ERASED_WORD;
    shadow_log[nxt*16 + HDR_SLOT] = {ROW_MARK, seq, 16'hFFFF};
    cur_row = nxt;
    cur_slot = 0;
  endtask

  // Work out the result of one word and update the shadow log.
  task automatic predict_word(in_t w);
    out_t r;
    logic [31:0] rec;
    logic [7:0] best, d;
    int unsigned row, slot;
    bit walking;
    r.ok = 1'b1;
    r.found_value = '0;
    case (opcode_e'(w.opcode))
      OP_PUT, OP_DELETE: begin
        rec = '0;
        rec[7:0] = (opcode_e'(w.opcode) == OP_PUT) ? TAG_PUT : TAG_DEL;
        rec[15:8] = w.key[10:3];
        rec[23:21] = w.key[2:0];
        rec[20:16] = (opcode_e'(w.opcode) == OP_PUT) ? w.value : 5'd0;
        rec[31:24] = record_crc(rec);
        shadow_log[cur_row*16 + cur_slot] = rec;
        cur_slot++;
        if (cur_slot >= 15) advance_row();
      end
      OP_RECOVER: begin
        best = 8'd0;
        cur_row = 0;
        for (int r2 = 0; r2 < ROWS; r2++) begin
          rec = shadow_log[r2*16 + HDR_SLOT];
          d = rec[23:16] - best;
          if (rec[31:24] == ROW_MARK && d >= 1 && d <= 127) begin
            best = rec[23:16];
            cur_row = r2;
          end
        end
        walking = 1'b1;
        for (int s = 0; s < 15 && walking; s++) begin
          if (!record_good(shadow_log[cur_row*16 + s])) begin
            cur_slot = s;
            walking = 1'b0;
          end
        end
        if (walking) advance_row();
      end
      default: begin
        // Backward walk for the newest record of the key.
        row = cur_row;
        slot = cur_slot;
        walking = 1'b1;
        r.ok = 1'b0;
        while (walking) begin
          if (slot == 0) begin
            row = (row == 0) ? ROWS - 1 : row - 1;
            slot = LAST_SLOT;
          end else begin
            slot--;
          end
          rec = shadow_log[row*16 + slot];
          if (!record_good(rec)) begin
            walking = 1'b0;
          end else if ({rec[15:8], rec[23:21]} == w.key) begin
            walking = 1'b0;
            if (rec[7:0] != TAG_DEL) begin
              r.ok = 1'b1;
              r.found_value = rec[20:16];
            end
          end else if (row == cur_row && slot == 0) begin
            walking = 1'b0;
          end
        end
      end
    endcase
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic in_t make_word(opcode_e op, int unsigned key, int unsigned val);
    in_t w;
    w.opcode = op;
    w.key = key[10:0];
    w.value = val[4:0];
    return w;
  endfunction

  // Driver: offers pending words, idling now and then.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_word(in_i);
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (pending_words.size() > 0 && !quiet_sender && !hold_armed
            && (stim_done || $urandom_range(99) >= 9)) begin
          in_valid_i <= 1'b1;
          in_i <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_o.ok !== want.ok) report_mismatch("ok", out_o.ok, want.ok);
          if (out_o.found_value !== want.found_value)
            report_mismatch("found_value", out_o.found_value, want.found_value);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet_receiver || ($urandom_range(99) >= 9);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned hot_keys [8];
    int unsigned k;
    opcode_e op;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 8; i++) hot_keys[i] = $urandom_range(2047);

    // Directed part: extremes, every operation, delete, lookup miss, recover.
    pending_words.push_back(make_word(OP_GET, 0, 0));
    pending_words.push_back(make_word(OP_RECOVER, 0, 0));
    pending_words.push_back(make_word(OP_PUT, 0, 0));
    pending_words.push_back(make_word(OP_PUT, 2047, 31));
    pending_words.push_back(make_word(OP_GET, 0, 0));
    pending_words.push_back(make_word(OP_GET, 2047, 0));
    pending_words.push_back(make_word(OP_DELETE, 2047, 31));
    pending_words.push_back(make_word(OP_GET, 2047, 0));
    pending_words.push_back(make_word(OP_GET, 1234, 0));
    for (int i = 0; i < 14; i++) pending_words.push_back(make_word(OP_PUT, 1365 + i, i + 17));
    pending_words.push_back(make_word(OP_RECOVER, 0, 0));
    pending_words.push_back(make_word(OP_GET, 0, 0));

    // Random part, mostly on a small set of keys so that lookups hit.
    for (int i = 0; i < 500; i++) begin
      k = ($urandom_range(3) == 0) ? $urandom_range(2047) : hot_keys[$urandom_range(7)];
      case ($urandom_range(19))
        0: op = OP_RECOVER;
        1, 2: op = OP_DELETE;
        3, 4, 5, 6, 7, 8, 9, 10: op = OP_PUT;
        default: op = OP_GET;
      endcase
      pending_words.push_back(make_word(op, k, $urandom_range(31)));
      // Long receiver hold-off while words keep coming.
      if (i == 150) begin
        wait (pending_words.size() < 300);
        hold_cycles = 400;
      end
      // Sender pause until everything has drained.
      if (i == 300) begin
        wait (pending_words.size() == 0);
        hold_armed = 1'b1;
        @(posedge clk_i);
        wait (expected_results.size() == 0 && !in_valid_i);
        hold_armed = 1'b0;
      end
    end
    // Last stretch with no idling on either side.
    wait (pending_words.size() < 80);
    quiet_receiver = 1'b1;
    stim_done = 1'b1;
    wait (pending_words.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    @(posedge clk_i);
    wait (expected_results.size() == 0);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Shadow log starts erased.
  initial begin
    for (int i = 0; i < WORDS; i++) shadow_log[i] = ERASED_WORD;
    cur_row = 0;
    cur_slot = 0;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/wlkv_pkg.sv
rtl/core/wlkv_ctrl.sv
rtl/core/wlkv_dp.sv
rtl/core/wear_levelled_log_kv_store.sv
bench/wear_levelled_log_kv_store_tb.sv
